@@ sv/rdbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rdbm_pkg
// Shared codes, constants and controller/datapath interface types for the
// RAM-disk bank mapper.
// ----------------------------------------------------------------------------
package rdbm_pkg;

  // command codes
  localparam logic [2:0] CMD_RD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_WR_BYTE   = 3'd1;
  localparam logic [2:0] CMD_RD_WORD   = 3'd2;
  localparam logic [2:0] CMD_RD_SCREEN = 3'd3;
  localparam logic [2:0] CMD_SET_MODE  = 3'd4;

  // address space codes
  localparam logic [1:0] SPACE_CPU    = 2'd0;
  localparam logic [1:0] SPACE_STACK  = 2'd1;
  localparam logic [1:0] SPACE_GLOBAL = 2'd2;

  localparam int unsigned PAGE_BITS = 16;

  // mapping windows
  localparam logic [15:0] WIN_A_LO = 16'hA000;
  localparam logic [15:0] WIN_A_HI = 16'hDFFF;
  localparam logic [15:0] WIN_8_LO = 16'h8000;
  localparam logic [15:0] WIN_8_HI = 16'h9FFF;
  localparam logic [15:0] WIN_E_LO = 16'hE000;

  // screen planes start at 8000 and follow every 2000
  localparam logic [19:0] SCREEN_BASE  = 20'h08000;
  localparam int unsigned PLANE_SHIFT  = 13;

  // mode byte E8AsSSMM
  localparam int unsigned MODE_WIN_LSB   = 5;
  localparam int unsigned MODE_STACK_EN  = 4;
  localparam int unsigned MODE_SPAGE_LSB = 2;
  localparam int unsigned MODE_RPAGE_LSB = 0;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic [1:0] beat;
    logic       clear;
    logic       out_load;
  } rdbm_cmd_t;

  typedef struct packed {
    logic [2:0] beats;
    logic       clr_last;
  } rdbm_sts_t;

endpackage

@@ sv/rdbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdbm_ctrl
// Sequencer: clearing pass after reset, then one transaction at a time,
// one memory beat per cycle, and the output valid flag.
// ----------------------------------------------------------------------------
module rdbm_ctrl
  import rdbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rdbm_cmd_t cmd,
  input  rdbm_sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] beat_r, beat_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       last_beat;

  assign last_beat = (3'({1'b0, beat_r}) + 3'd1) == sts.beats;

  always_comb begin
    state_nxt     = state_r;
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.beat      = beat_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          beat_nxt  = 2'd0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        beat_nxt  = beat_r + 2'd1;
        if (last_beat) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      beat_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/rdbm_dp.sv @@
// ----------------------------------------------------------------------------
// rdbm_dp
// Datapath: transaction registers, mapping mode, address mapping, the byte
// store with its registered read port, and the result assembly.
// ----------------------------------------------------------------------------
module rdbm_dp
  import rdbm_pkg::*;
#(
  parameter int RAM_DISK_PAGES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_command,
  input  logic [18:0] in_address,
  input  logic [1:0]  in_space,
  input  logic [7:0]  in_write_data,
  input  rdbm_cmd_t   cmd,
  output rdbm_sts_t   sts,
  output logic [31:0] out_read_data
);

  localparam int NumBanks = RAM_DISK_PAGES + 1;
  localparam int Depth    = NumBanks * (2 ** PAGE_BITS);
  localparam int AW       = $clog2(Depth);
  localparam int BW       = AW - PAGE_BITS;

  // bank number modulo the bank count; the raw value never exceeds 8
  function automatic logic [BW-1:0] bank_wrap(input logic [3:0] hi);
    logic [3:0] r;
    r = hi;
    for (int i = 0; i < 4; i++) begin
      if (r >= 4'(NumBanks)) begin
        r = r - 4'(NumBanks);
      end
    end
    return r[BW-1:0];
  endfunction

  logic [7:0]  mem_q [0:Depth-1];

  logic [2:0]  cmd_r;
  logic [18:0] addr_r;
  logic [1:0]  space_r;
  logic [7:0]  data_r;
  logic [2:0]  win_en_r;
  logic        stack_en_r;
  logic [1:0]  stack_page_r;
  logic [1:0]  ram_page_r;
  logic [AW-1:0] clr_cnt_r;
  logic        cap_r;
  logic [7:0]  rdata_r;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] out_data_r;

  logic [19:0]   src;
  logic          glob;
  logic [15:0]   lo;
  logic [3:0]    hi;
  logic          in_win;
  logic [AW-1:0] mem_addr;
  logic          is_read;
  logic          we;
  logic [7:0]    wdata;

  always_comb begin
    src  = {1'b0, addr_r};
    glob = (space_r == SPACE_GLOBAL);
    if (cmd_r == CMD_RD_WORD && cmd.beat == 2'd0) begin
      // high byte first, it ends up in bits 15:8
      src = {1'b0, addr_r} + 20'd1;
    end else if (cmd_r == CMD_RD_SCREEN) begin
      src  = 20'(addr_r[15:0]) + SCREEN_BASE + (20'(cmd.beat) << PLANE_SHIFT);
      glob = 1'b1;
    end
    lo     = src[15:0];
    in_win = (win_en_r[0] && lo >= WIN_A_LO && lo <= WIN_A_HI) ||
             (win_en_r[1] && lo >= WIN_8_LO && lo <= WIN_8_HI) ||
             (win_en_r[2] && lo >= WIN_E_LO);
    if (glob) begin
      hi = src[19:16];
    end else if (stack_en_r && space_r == SPACE_STACK) begin
      hi = {2'b00, stack_page_r} + 4'd1;
    end else if (in_win) begin
      hi = {2'b00, ram_page_r} + 4'd1;
    end else begin
      hi = 4'd0;
    end
    mem_addr = cmd.clear ? clr_cnt_r : {bank_wrap(hi), lo};
  end

  assign is_read = cmd.issue &&
                   (cmd_r == CMD_RD_BYTE || cmd_r == CMD_RD_WORD || cmd_r == CMD_RD_SCREEN);
  assign we      = cmd.clear || (cmd.issue && cmd_r == CMD_WR_BYTE);
  assign wdata   = cmd.clear ? 8'd0 : data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[mem_addr] <= wdata;
    end
    rdata_r <= mem_q[mem_addr];
  end

  always_comb begin
    unique case (cmd_r)
      CMD_RD_WORD:   sts.beats = 3'd2;
      CMD_RD_SCREEN: sts.beats = 3'd4;
      default:       sts.beats = 3'd1;
    endcase
    sts.clr_last = (clr_cnt_r == AW'(Depth - 1));
  end

  assign acc_nxt = cap_r ? {acc_r[23:0], rdata_r} : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      cap_r        <= 1'b0;
      win_en_r     <= 3'd0;
      stack_en_r   <= 1'b0;
      stack_page_r <= 2'd0;
      ram_page_r   <= 2'd0;
    end else begin
      cap_r <= is_read;
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.issue && cmd_r == CMD_SET_MODE) begin
        win_en_r     <= data_r[MODE_WIN_LSB +: 3];
        stack_en_r   <= data_r[MODE_STACK_EN];
        stack_page_r <= data_r[MODE_SPAGE_LSB +: 2];
        ram_page_r   <= data_r[MODE_RPAGE_LSB +: 2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      addr_r  <= in_address;
      space_r <= in_space;
      data_r  <= in_write_data;
      acc_r   <= 32'd0;
    end else begin
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= acc_nxt;
    end
  end

  assign out_read_data = out_data_r;

endmodule

@@ sv/ram_disk_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// ram_disk_bank_mapper
// Byte store of 64 KiB main RAM plus RAM-disk pages with bank-mapped CPU
// accesses, stack mapping, global accesses and four-plane screen reads.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the whole store, one byte
// per cycle, zeroing (RAM_DISK_PAGES + 1) * 65536 bytes (327680 by default);
// in_ready stays low until it ends. Afterwards one transaction is handled at
// a time through the single-port byte memory, one byte per cycle: byte
// reads, byte writes, set mode and unused commands make one access, a word
// read fetches two bytes and a screen read four, and in_ready rises as the
// result enters the output register. A result that is not taken holds the
// next one back, but a new transaction is accepted while a result waits.
module ram_disk_bank_mapper
  import rdbm_pkg::*;
#(
  parameter int RAM_DISK_PAGES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [18:0] in_address,
  input  logic [1:0]  in_space,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data
);

  rdbm_cmd_t cmd;
  rdbm_sts_t sts;

  rdbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rdbm_dp #(
    .RAM_DISK_PAGES (RAM_DISK_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_space      (in_space),
    .in_write_data (in_write_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_read_data (out_read_data)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RAM-disk bank mapper: random and directed memory
// transactions are predicted against a shadow store and mapping registers,
// and every returned read_data is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rdbm_pkg::*;

  localparam int          RAM_DISK_PAGES = 4;
  localparam int unsigned PAGE_BYTES     = 32'h10000;
  localparam int unsigned TOTAL_BYTES    = PAGE_BYTES * (RAM_DISK_PAGES + 1);
  localparam int          PHASE_ITEMS    = 256;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          TAIL_CYCLES    = 20;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [1:0] SPACE_SPARE  = 2'd3;

  typedef struct {
    logic [2:0]  command;
    logic [18:0] address;
    logic [1:0]  space;
    logic [7:0]  write_data;
  } mem_op_t;

  typedef struct {
    mem_op_t     op;
    logic [31:0] data;
  } read_expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [18:0] in_address = '0;
  logic [1:0]  in_space = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;

  // shadow of the block's state
  logic [7:0] shadow_mem [TOTAL_BYTES];
  logic [2:0] win_en;
  logic [1:0] ram_pg;
  logic       stk_en;
  logic [1:0] stk_pg;

  mem_op_t      pending_ops[$];
  read_expect_t expected_reads[$];
  logic [15:0]  hot_offsets[8];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;

  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  mem_op_t      drive_op;
  read_expect_t got_expect;

  ram_disk_bank_mapper #(
    .RAM_DISK_PAGES(RAM_DISK_PAGES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_address(in_address),
    .in_space(in_space),
    .in_write_data(in_write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_read_data(out_read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit in_ram_window(int unsigned a);
    if (win_en[0] && a >= WIN_A_LO && a <= WIN_A_HI) return 1'b1;
    if (win_en[1] && a >= WIN_8_LO && a <= WIN_8_HI) return 1'b1;
    if (win_en[2] && a >= WIN_E_LO) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned map_address(int unsigned addr, logic [1:0] space);
    int unsigned a;
    a = addr & 32'hFFFF;
    if (space == SPACE_GLOBAL) return addr % TOTAL_BYTES;
    if (stk_en && space == SPACE_STACK)
      return (a + (int'(stk_pg) + 1) * PAGE_BYTES) % TOTAL_BYTES;
    if (in_ram_window(a))
      return (a + (int'(ram_pg) + 1) * PAGE_BYTES) % TOTAL_BYTES;
    return a;
  endfunction

  // updates the shadow state and returns the read_data the transaction should give
  function automatic logic [31:0] apply_mem_op(mem_op_t op);
    logic [31:0] data;
    int unsigned addr;
    int unsigned off;
    data = '0;
    addr = op.address;
    case (op.command)
      CMD_RD_BYTE: data = shadow_mem[map_address(addr, op.space)];
      CMD_WR_BYTE: shadow_mem[map_address(addr, op.space)] = op.write_data;
      CMD_RD_WORD: data = {shadow_mem[map_address(addr + 1, op.space)],
                           shadow_mem[map_address(addr, op.space)]};
      CMD_RD_SCREEN: begin
        off = addr & 32'hFFFF;
        // planes 8000, A000, C000, E000 packed high to low, unmapped
        for (int k = 0; k < 4; k++)
          data = {data[23:0],
                  shadow_mem[(off + SCREEN_BASE + (k << PLANE_SHIFT)) % TOTAL_BYTES]};
      end
      CMD_SET_MODE: begin
        win_en = op.write_data[MODE_WIN_LSB +: 3];
        stk_en = op.write_data[MODE_STACK_EN];
        stk_pg = op.write_data[MODE_SPAGE_LSB +: 2];
        ram_pg = op.write_data[MODE_RPAGE_LSB +: 2];
      end
      default: data = '0;
    endcase
    return data;
  endfunction

  function automatic mem_op_t random_op();
    mem_op_t     op;
    int          pick;
    logic [15:0] low;
    logic [2:0]  page;
    pick = $urandom_range(0, 99);
    if (pick < 30) op.command = CMD_WR_BYTE;
    else if (pick < 50) op.command = CMD_RD_BYTE;
    else if (pick < 65) op.command = CMD_RD_WORD;
    else if (pick < 78) op.command = CMD_RD_SCREEN;
    else if (pick < 92) op.command = CMD_SET_MODE;
    else op.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    pick = $urandom_range(0, 99);
    if (pick < 40) op.space = SPACE_CPU;
    else if (pick < 60) op.space = SPACE_STACK;
    else if (pick < 90) op.space = SPACE_GLOBAL;
    else op.space = SPACE_SPARE;
    // mostly keep addresses on the eight hot offsets and their screen-plane aliases so reads hit data
    if ($urandom_range(0, 99) < 15) begin
      low = 16'($urandom);
    end else begin
      low = hot_offsets[$urandom_range(0, 7)];
      case ($urandom_range(0, 4))
        0: low = low;
        1: low = low + WIN_8_LO;
        2: low = low + WIN_A_LO;
        3: low = low + 16'hC000;
        default: low = low + WIN_E_LO;
      endcase
      if ($urandom_range(0, 3) == 0) low = low + 16'd1;
    end
    page = 3'($urandom_range(0, RAM_DISK_PAGES));
    op.address = {page, low};
    op.write_data = 8'($urandom);
    return op;
  endfunction

  task automatic push_op(logic [2:0] cmd, logic [18:0] addr, logic [1:0] space,
                         logic [7:0] data);
    mem_op_t op;
    op.command = cmd;
    op.address = addr;
    op.space = space;
    op.write_data = data;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_reads.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string what, mem_op_t op, logic [31:0] got,
                                 logic [31:0] want);
    $display("mismatch: %s cmd=%0d addr=%h space=%0d wdata=%h got=%h want=%h",
             what, op.command, op.address, op.space, op.write_data, got, want);
    error_count++;
  endtask

  // driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        got_expect.op.command = in_command;
        got_expect.op.address = in_address;
        got_expect.op.space = in_space;
        got_expect.op.write_data = in_write_data;
        got_expect.data = apply_mem_op(got_expect.op);
        expected_reads.push_back(got_expect);
      end
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_op = pending_ops.pop_front();
        in_command <= drive_op.command;
        in_address <= drive_op.address;
        in_space <= drive_op.space;
        in_write_data <= drive_op.write_data;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps going meanwhile
  always @(posedge clk) begin
    hold_seen <= hold_req;
    if (hold_req != hold_seen) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_left != 0 || hold_req != hold_seen) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        got_expect.op = '{default: '0};
        report_mismatch("unexpected result", got_expect.op, out_read_data, '0);
      end else begin
        got_expect = expected_reads.pop_front();
        if (out_read_data !== got_expect.data)
          report_mismatch("read_data", got_expect.op, out_read_data, got_expect.data);
      end
    end
  end

  initial begin
    for (int i = 0; i < TOTAL_BYTES; i++) shadow_mem[i] = 8'h00;
    win_en = '0;
    ram_pg = '0;
    stk_en = 1'b0;
    stk_pg = '0;
    hot_offsets[0] = 16'h0000;
    hot_offsets[1] = 16'h1FFF;
    hot_offsets[2] = 16'hFFFF;
    for (int i = 3; i < 8; i++) hot_offsets[i] = 16'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed transactions, queued before the clearing pass ends
    push_op(CMD_RD_BYTE,   19'h00000, SPACE_CPU,    8'h00);
    push_op(CMD_WR_BYTE,   19'h00000, SPACE_GLOBAL, 8'hFF);
    push_op(CMD_WR_BYTE,   19'h4FFFF, SPACE_GLOBAL, 8'hA5);
    push_op(CMD_RD_WORD,   19'h4FFFF, SPACE_GLOBAL, 8'h00);  // wraps to the store start
    push_op(CMD_WR_BYTE,   19'h7FFFF, SPACE_CPU,    8'h5A);  // upper bits ignored
    push_op(CMD_RD_WORD,   19'h0FFFF, SPACE_CPU,    8'h00);  // wraps within 16 bits
    push_op(CMD_RD_BYTE,   19'h0FFFF, SPACE_GLOBAL, 8'h00);
    push_op(CMD_SET_MODE,  19'h00000, SPACE_CPU,    8'hFF);  // all windows, stack page 3
    push_op(CMD_WR_BYTE,   19'h0A000, SPACE_CPU,    8'h11);
    push_op(CMD_WR_BYTE,   19'h09FFF, SPACE_SPARE,  8'h22);  // spare space acts as cpu
    push_op(CMD_WR_BYTE,   19'h0E000, SPACE_CPU,    8'h33);
    push_op(CMD_WR_BYTE,   19'h01234, SPACE_STACK,  8'h44);
    push_op(CMD_RD_BYTE,   19'h41234, SPACE_GLOBAL, 8'h00);
    push_op(CMD_RD_SCREEN, 19'h42000, SPACE_CPU,    8'h00);
    push_op(CMD_SET_MODE,  19'h00000, SPACE_CPU,    8'h00);
    push_op(CMD_RD_WORD,   19'h09FFF, SPACE_CPU,    8'h00);
    push_op(CMD_RD_BYTE,   19'h0A000, SPACE_STACK,  8'h00);
    push_op(CMD_RD_SCREEN, 19'h0FFFF, SPACE_GLOBAL, 8'h00);
    push_op(CMD_WR_BYTE,   19'h08000, SPACE_GLOBAL, 8'h01);
    push_op(CMD_WR_BYTE,   19'h0A000, SPACE_GLOBAL, 8'h02);
    push_op(CMD_WR_BYTE,   19'h0C000, SPACE_GLOBAL, 8'h03);
    push_op(CMD_WR_BYTE,   19'h0E000, SPACE_GLOBAL, 8'h04);
    push_op(CMD_RD_SCREEN, 19'h30000, SPACE_STACK,  8'h00);
    push_op(CMD_SPARE_LO,  19'h0A000, SPACE_CPU,    8'h77);
    push_op(CMD_SPARE_HI,  19'h00000, SPACE_GLOBAL, 8'h88);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) pending_ops.push_back(random_op());
      if (ph == 0) begin
        @(posedge clk);
        hold_req <= ~hold_req;
      end
      // sender pauses here until every result of the phase is back
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/rdbm_pkg.sv
sv/rdbm_ctrl.sv
sv/rdbm_dp.sv
sv/ram_disk_bank_mapper.sv
tb/tb_top.sv
